/* hdl/spk_pkg.sv */
// Shared types, constants and rotate helpers for the Speck48/96 core.
`timescale 1ns / 1ps
`default_nettype none

package spk_pkg;

   localparam int ROUNDS     = 23;
   localparam int WORD_WIDTH = 24;
   localparam int IDX_WIDTH  = $clog2(ROUNDS);

   localparam logic [IDX_WIDTH-1:0] FIRST_ROUND  = '0;
   localparam logic [IDX_WIDTH-1:0] LAST_ROUND   = IDX_WIDTH'(ROUNDS - 1);
   localparam logic [IDX_WIDTH-1:0] LAST_EXPAND  = IDX_WIDTH'(ROUNDS - 2);

   typedef logic [WORD_WIDTH-1:0] word_type;

   typedef enum logic [1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic     func;
      word_type block_low;
      word_type block_high;
   } req_word_type;

   typedef struct packed {
      word_type result_low;
      word_type result_high;
   } rsp_word_type;

   typedef struct packed {
      logic                 load;
      logic                 key_step;
      logic                 round_step;
      logic                 decrypt;
      logic [IDX_WIDTH-1:0] round_idx;
      logic [IDX_WIDTH-1:0] rd_idx;
   } seq_ctrl_type;

   function automatic word_type ror8(input word_type v);
      return {v[7:0], v[23:8]};
   endfunction

   function automatic word_type rol8(input word_type v);
      return {v[15:0], v[23:16]};
   endfunction

   function automatic word_type ror3(input word_type v);
      return {v[2:0], v[23:3]};
   endfunction

   function automatic word_type rol3(input word_type v);
      return {v[20:0], v[23:21]};
   endfunction

endpackage

`default_nettype wire

/* hdl/spk_key_unit.sv */
// Key schedule unit: one round key per step, round key store for decryption.
`timescale 1ns / 1ps
`default_nettype none

module spk_key_unit
   import spk_pkg::*;
(
   input  wire logic         clock,
   input  wire seq_ctrl_type ctrl,
   input  wire word_type     key_word0,
   input  wire word_type     key_word1,
   input  wire word_type     key_word2,
   input  wire word_type     key_word3,
   output word_type          rk_cur,
   output word_type          rk_rd
);

   word_type rk_ff, rk_in;
   word_type l0_ff, l0_in;
   word_type l1_ff, l1_in;
   word_type l2_ff, l2_in;
   word_type nl;
   word_type rk_next;
   word_type rk_rd_ff;
   word_type rk_mem [ROUNDS];

   always_comb begin
      nl      = (ror8(l0_ff) + rk_ff) ^ WORD_WIDTH'(ctrl.round_idx);
      rk_next = rol3(rk_ff) ^ nl;
      rk_in   = rk_ff;
      l0_in   = l0_ff;
      l1_in   = l1_ff;
      l2_in   = l2_ff;
      if (ctrl.load) begin
         rk_in = key_word3;
         l0_in = key_word2;
         l1_in = key_word1;
         l2_in = key_word0;
      end else if (ctrl.key_step) begin
         rk_in = rk_next;
         l0_in = l1_ff;
         l1_in = l2_ff;
         l2_in = nl;
      end
   end

   always_ff @(posedge clock) begin
      rk_ff <= rk_in;
      l0_ff <= l0_in;
      l1_ff <= l1_in;
      l2_ff <= l2_in;
      if (ctrl.load) begin
         rk_mem[FIRST_ROUND] <= key_word3;
      end else if (ctrl.key_step && ctrl.round_idx != LAST_ROUND) begin
         rk_mem[ctrl.round_idx + 1'b1] <= rk_next;
      end
      // read for next cycle's round; bypass the key being written this cycle
      if (ctrl.key_step && (ctrl.round_idx + 1'b1) == ctrl.rd_idx) begin
         rk_rd_ff <= rk_next;
      end else begin
         rk_rd_ff <= rk_mem[ctrl.rd_idx];
      end
   end

   assign rk_cur = rk_ff;
   assign rk_rd  = rk_rd_ff;

endmodule

`default_nettype wire

/* hdl/spk_round_unit.sv */
// Round unit: block state and one encrypt or decrypt round per step.
`timescale 1ns / 1ps
`default_nettype none

module spk_round_unit
   import spk_pkg::*;
(
   input  wire logic         clock,
   input  wire seq_ctrl_type ctrl,
   input  wire req_word_type req_word,
   input  wire word_type     round_key,
   output rsp_word_type      rsp_word
);

   word_type x_ff, x_in;
   word_type y_ff, y_in;
   word_type enc_x, enc_y;
   word_type dec_x, dec_y;

   always_comb begin
      enc_x = (ror8(x_ff) + y_ff) ^ round_key;
      enc_y = rol3(y_ff) ^ enc_x;
      dec_y = ror3(y_ff ^ x_ff);
      dec_x = rol8((x_ff ^ round_key) - dec_y);
      x_in  = x_ff;
      y_in  = y_ff;
      if (ctrl.load) begin
         x_in = req_word.block_low;
         y_in = req_word.block_high;
      end else if (ctrl.round_step) begin
         x_in = ctrl.decrypt ? dec_x : enc_x;
         y_in = ctrl.decrypt ? dec_y : enc_y;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
   end

   assign rsp_word.result_low  = x_ff;
   assign rsp_word.result_high = y_ff;

endmodule

`default_nettype wire

/* hdl/speck48_96_block_cipher.sv */
// Speck48/96 block cipher core: key registers, sequencer and datapath.
//
// A word is accepted when start is high and busy is low. Encryption runs the
// key schedule alongside the rounds, one round per cycle in the shared round
// unit. Decryption first expands the key into the round key store and then
// runs the 23 inverse rounds in reverse key order. The result is on rsp_word
// for one cycle with rsp_strobe high, in the first cycle in which busy is low;
// the receiver cannot stall it, so it must take the word in that cycle. A new
// start may be given in that same cycle. Key writes take effect on the next
// accepted word; the user must see that they are only made while busy is low,
// as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module speck48_96_block_cipher
   import spk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_word_type req_word,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word,
   input  wire logic         csr_write_enable,
   input  wire logic [1:0]   csr_index,
   input  wire word_type     csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ENC    = 4'b0010,
      ST_EXPAND = 4'b0100,
      ST_DEC    = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 dec_ff, dec_in;
   logic                 strobe_ff, strobe_in;
   word_type             key_word0_ff, key_word1_ff, key_word2_ff, key_word3_ff;
   seq_ctrl_type         ctrl;
   word_type             rk_cur, rk_rd, round_key;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_word0_ff <= '0;
         key_word1_ff <= '0;
         key_word2_ff <= '0;
         key_word3_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_WORD0: key_word0_ff <= csr_write_data;
            CSR_KEY_WORD1: key_word1_ff <= csr_write_data;
            CSR_KEY_WORD2: key_word2_ff <= csr_write_data;
            CSR_KEY_WORD3: key_word3_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      dec_in          = dec_ff;
      strobe_in       = 1'b0;
      ctrl.load       = 1'b0;
      ctrl.key_step   = 1'b0;
      ctrl.round_step = 1'b0;
      ctrl.decrypt    = dec_ff;
      ctrl.round_idx  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               dec_in    = req_word.func;
               cnt_in    = FIRST_ROUND;
               state_in  = req_word.func ? ST_EXPAND : ST_ENC;
            end
         end
         ST_ENC: begin
            ctrl.key_step   = 1'b1;
            ctrl.round_step = 1'b1;
            if (cnt_ff == LAST_ROUND) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_EXPAND: begin
            ctrl.key_step = 1'b1;
            if (cnt_ff == LAST_EXPAND) begin
               cnt_in   = LAST_ROUND;
               state_in = ST_DEC;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DEC: begin
            ctrl.round_step = 1'b1;
            if (cnt_ff == FIRST_ROUND) begin
               strobe_in = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ctrl.rd_idx = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         dec_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         dec_ff    <= dec_in;
         strobe_ff <= strobe_in;
      end
   end

   assign round_key = dec_ff ? rk_rd : rk_cur;

   spk_key_unit u_key (
      .clock     (clock),
      .ctrl      (ctrl),
      .key_word0 (key_word0_ff),
      .key_word1 (key_word1_ff),
      .key_word2 (key_word2_ff),
      .key_word3 (key_word3_ff),
      .rk_cur    (rk_cur),
      .rk_rd     (rk_rd)
   );

   spk_round_unit u_round (
      .clock     (clock),
      .ctrl      (ctrl),
      .req_word  (req_word),
      .round_key (round_key),
      .rsp_word  (rsp_word)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire
